// File: rtl/gcd_pkg.sv
// Package for the genome compatibility distance block.
// Types, constants and state codes; used by genome_compatibility_distance.
package gcd_pkg;

    localparam int MaxGenes   = 1024;
    localparam int AddrW      = $clog2(MaxGenes);
    localparam int LenW       = AddrW + 1;
    localparam int IdW        = 16;
    localparam int WtW        = 24;
    localparam int GeneW      = IdW + WtW;
    // wide accumulator for matched weight sum (25 bits * up to MaxGenes)
    localparam int WsumW      = WtW + 1 + LenW;
    localparam int PaddrW     = 4;

    localparam logic [PaddrW-1:0] AddrExcess   = 4'h0;
    localparam logic [PaddrW-1:0] AddrDisjoint = 4'h4;
    localparam logic [PaddrW-1:0] AddrMatched  = 4'h8;

    localparam logic [15:0] ExcessReset   = 16'd4096;
    localparam logic [15:0] DisjointReset = 16'd4096;
    localparam logic [15:0] MatchedReset  = 16'd1638;

    typedef struct packed {
        logic                  op;
        logic [IdW-1:0]        innovation;
        logic signed [WtW-1:0] weight;
        logic                  last;
    } gene_word_t;

    typedef struct packed {
        logic [23:0] score;
        logic [10:0] excess_count;
        logic [11:0] disjoint_count;
        logic [10:0] matched_count;
        logic        no_match;
    } result_word_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD,
        ST_CMP,
        ST_TAIL,
        ST_MUL1,
        ST_MUL2,
        ST_DIV1,
        ST_DIV2,
        ST_DIV2R,
        ST_OUT
    } state_t;

endpackage

// File: rtl/genome_compatibility_distance.sv
// Top level: genome compatibility distance. Needs gcd_pkg, gcd_ram, gcd_div.
// Flow: genes load into the A and B stores; the final B word starts a merge walk
// with the ST_RD and ST_CMP states for each step (at most lenA+lenB steps), the
// multiply states ST_MUL1 and ST_MUL2, up to two divisions on the shared
// bit-serial divider, then the result. A new list pair loads only after the
// output state hands the distance over; it waits while an earlier one is held.
// Reset: synchronous active low; lengths cleared, coefficients to defaults.
module genome_compatibility_distance (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gcd_pkg::gene_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gcd_pkg::result_word_t m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [gcd_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int AW = gcd_pkg::AddrW;
    localparam int LW = gcd_pkg::LenW;
    localparam int WtW_ = gcd_pkg::WtW;

    gcd_pkg::state_t state_reg, state_next;
    logic [15:0] ce_reg, cd_reg, cm_reg;
    logic [LW-1:0] len_a_reg, len_a_next, len_b_reg, len_b_next;
    logic [LW-1:0] g1_reg, g1_next, g2_reg, g2_next;
    logic [LW-1:0] nm_reg, nm_next;
    logic [LW:0]   nd_reg, nd_next;
    logic [gcd_pkg::WsumW-1:0] ws_reg, ws_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] term_reg, term_next;
    logic [63:0] prod_reg, prod_next;
    gcd_pkg::result_word_t res_reg, res_next;
    gcd_pkg::result_word_t out_reg, out_next;
    logic mvalid_reg, mvalid_next;

    logic [gcd_pkg::GeneW-1:0] a_rd, b_rd;
    logic we_a, we_b;
    logic [AW-1:0] ra, rb;
    logic [LW:0] ne;
    logic [LW-1:0] longest;
    logic div_start, div_done;
    logic [63:0] div_num, quo;
    logic [31:0] div_den;
    logic signed [WtW_:0] dw;
    logic [WtW_:0] adw;
    logic [64:0] total;

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ce_reg <= gcd_pkg::ExcessReset;
            cd_reg <= gcd_pkg::DisjointReset;
            cm_reg <= gcd_pkg::MatchedReset;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                gcd_pkg::AddrExcess:   ce_reg <= pwdata[15:0];
                gcd_pkg::AddrDisjoint: cd_reg <= pwdata[15:0];
                gcd_pkg::AddrMatched:  cm_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr)
            gcd_pkg::AddrExcess:   prdata = {16'd0, ce_reg};
            gcd_pkg::AddrDisjoint: prdata = {16'd0, cd_reg};
            gcd_pkg::AddrMatched:  prdata = {16'd0, cm_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // gene stores
    assign s_ready = (state_reg == gcd_pkg::ST_LOAD);
    assign we_a = s_valid && s_ready && !s_data.op && (len_a_reg < LW'(gcd_pkg::MaxGenes));
    assign we_b = s_valid && s_ready && s_data.op && (len_b_reg < LW'(gcd_pkg::MaxGenes));
    assign ra = g1_reg[AW-1:0];
    assign rb = g2_reg[AW-1:0];

    gcd_ram #(.Width(gcd_pkg::GeneW), .Depth(gcd_pkg::MaxGenes)) u_ram_a (
        .aclk(aclk), .we(we_a), .waddr(len_a_reg[AW-1:0]),
        .wdata({s_data.innovation, s_data.weight}), .raddr(ra), .rdata(a_rd));
    gcd_ram #(.Width(gcd_pkg::GeneW), .Depth(gcd_pkg::MaxGenes)) u_ram_b (
        .aclk(aclk), .we(we_b), .waddr(len_b_reg[AW-1:0]),
        .wdata({s_data.innovation, s_data.weight}), .raddr(rb), .rdata(b_rd));

    gcd_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_num), .divisor(div_den), .done(div_done), .quotient(quo));

    // merge-walk datapath
    assign dw  = $signed({a_rd[WtW_-1], a_rd[WtW_-1:0]}) - $signed({b_rd[WtW_-1], b_rd[WtW_-1:0]});
    assign adw = dw[WtW_] ? WtW_'(0) - dw : dw;
    assign ne  = (LW+1)'(len_a_reg - g1_reg) + (LW+1)'(len_b_reg - g2_reg);
    assign longest = (len_a_reg > len_b_reg) ? len_a_reg : len_b_reg;
    assign total = {1'b0, term_reg} + {1'b0, quo};

    // sequencer
    always_comb begin
        state_next  = state_reg;
        len_a_next  = len_a_reg;
        len_b_next  = len_b_reg;
        g1_next     = g1_reg;
        g2_next     = g2_reg;
        nm_next     = nm_reg;
        nd_next     = nd_reg;
        ws_next     = ws_reg;
        num_next    = num_reg;
        term_next   = term_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg;
        div_start   = 1'b0;
        div_num     = num_reg;
        div_den     = 32'(longest);
        if (m_valid && m_ready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            gcd_pkg::ST_LOAD: begin
                if (s_valid) begin
                    if (we_a) len_a_next = len_a_reg + LW'(1);
                    if (we_b) len_b_next = len_b_reg + LW'(1);
                    if (s_data.op && s_data.last) begin
                        g1_next = '0;
                        g2_next = '0;
                        nm_next = '0;
                        nd_next = '0;
                        ws_next = '0;
                        state_next = gcd_pkg::ST_RD;
                    end
                end
            end
            gcd_pkg::ST_RD: begin
                if (g1_reg < len_a_reg && g2_reg < len_b_reg) begin
                    state_next = gcd_pkg::ST_CMP;
                end else begin
                    state_next = gcd_pkg::ST_TAIL;
                end
            end
            gcd_pkg::ST_CMP: begin
                if (a_rd[gcd_pkg::GeneW-1 -: 16] == b_rd[gcd_pkg::GeneW-1 -: 16]) begin
                    ws_next = ws_reg + gcd_pkg::WsumW'(adw);
                    nm_next = nm_reg + LW'(1);
                    g1_next = g1_reg + LW'(1);
                    g2_next = g2_reg + LW'(1);
                end else if (a_rd[gcd_pkg::GeneW-1 -: 16] < b_rd[gcd_pkg::GeneW-1 -: 16]) begin
                    nd_next = nd_reg + (LW+1)'(1);
                    g1_next = g1_reg + LW'(1);
                end else begin
                    nd_next = nd_reg + (LW+1)'(1);
                    g2_next = g2_reg + LW'(1);
                end
                state_next = gcd_pkg::ST_RD;
            end
            gcd_pkg::ST_TAIL: begin
                res_next.excess_count   = 11'(ne);
                res_next.disjoint_count = 12'(nd_reg);
                res_next.matched_count  = 11'(nm_reg);
                res_next.no_match       = (nm_reg == '0);
                prod_next = 64'({16'd0, ce_reg} * 32'(ne));
                state_next = gcd_pkg::ST_MUL1;
            end
            gcd_pkg::ST_MUL1: begin
                num_next  = prod_reg + 64'({16'd0, cd_reg} * 32'(nd_reg));
                prod_next = 64'(cm_reg) * 64'(ws_reg);
                state_next = gcd_pkg::ST_MUL2;
            end
            gcd_pkg::ST_MUL2: begin
                num_next = {num_reg[59:0], 4'd0};
                if (longest == '0) begin
                    term_next  = '0;
                    state_next = gcd_pkg::ST_DIV2;
                end else begin
                    div_num    = {num_reg[59:0], 4'd0};
                    div_start  = 1'b1;
                    state_next = gcd_pkg::ST_DIV1;
                end
            end
            gcd_pkg::ST_DIV1: begin
                if (div_done) begin
                    term_next  = quo;
                    state_next = gcd_pkg::ST_DIV2;
                end
            end
            gcd_pkg::ST_DIV2: begin
                if (nm_reg == '0) begin
                    res_next.score = (term_reg > 64'hFFFFFF) ? 24'hFFFFFF : term_reg[23:0];
                    state_next = gcd_pkg::ST_OUT;
                end else begin
                    div_num    = prod_reg;
                    div_den    = {9'd0, nm_reg, 12'd0};
                    div_start  = 1'b1;
                    state_next = gcd_pkg::ST_DIV2R;
                end
            end
            gcd_pkg::ST_DIV2R: begin
                div_den = {9'd0, nm_reg, 12'd0};
                if (div_done) begin
                    res_next.score = (total > 65'hFFFFFF) ? 24'hFFFFFF : total[23:0];
                    state_next = gcd_pkg::ST_OUT;
                end
            end
            gcd_pkg::ST_OUT: begin
                // hand the finished distance to the output register once it is free
                if (!mvalid_reg || (m_valid && m_ready)) begin
                    out_next    = res_reg;
                    mvalid_next = 1'b1;
                    len_a_next  = '0;
                    len_b_next  = '0;
                    state_next  = gcd_pkg::ST_LOAD;
                end
            end
            default: state_next = gcd_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= gcd_pkg::ST_LOAD;
            len_a_reg  <= '0;
            len_b_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_a_reg  <= len_a_next;
            len_b_reg  <= len_b_next;
            mvalid_reg <= mvalid_next;
        end
        g1_reg   <= g1_next;
        g2_reg   <= g2_next;
        nm_reg   <= nm_next;
        nd_reg   <= nd_next;
        ws_reg   <= ws_next;
        num_reg  <= num_next;
        term_reg <= term_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;
endmodule

// File: rtl/gcd_ram.sv
// Generic single-port write, single read RAM with registered read data.
// No dependencies.
module gcd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/gcd_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module gcd_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    // one shift-subtract step a cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        trial     = shifted - {1'b0, divisor};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = busy_reg && (cnt_reg == 7'd63);
    assign quotient = {quo_reg[62:0], ~trial[32]};
endmodule
